// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define DBOPS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define DBOPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/dbops_pkg.sv =====
package dbops_pkg;

    localparam int PANEL_WIDTH  = 128;
    localparam int PANEL_HEIGHT = 128;

    localparam int PAGES       = PANEL_HEIGHT / 8;
    localparam int COL_W       = $clog2(PANEL_WIDTH);
    localparam int PAGE_W      = 4;
    localparam int OFF_W       = 11;
    localparam int ADDR_W      = OFF_W + 1;
    localparam int STORE_DEPTH = 1 << ADDR_W;
    localparam int CMD_BYTES   = 6;
    localparam int ADDR7_W     = 7;

    localparam logic [ADDR7_W-1:0] DEV_ADDR_RESET = 7'd60;

    localparam logic [7:0] CMD_CTRL  = 8'h00;
    localparam logic [7:0] DATA_CTRL = 8'h40;
    localparam logic [7:0] SET_PAGE  = 8'hB0;
    localparam logic [7:0] COL_HI    = 8'h10;
    localparam logic [7:0] COL_LO    = 8'h00;

    localparam logic [7:0] BIP_SET_PAGE = 8'd1;
    localparam logic [7:0] BIP_COL_HI   = 8'd3;
    localparam logic [7:0] BIP_DATA_HDR = 8'(CMD_BYTES);
    localparam logic [7:0] BIP_LAST     = 8'(CMD_BYTES + PANEL_WIDTH);

    typedef enum logic [1:0] {
        OP_DRAW  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_SWAP  = 2'd2,
        OP_PULL  = 2'd3
    } dbops_op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_DRAW_RD,
        ST_DRAW_WR,
        ST_CLEAR,
        ST_SWAP,
        ST_PULL_RD,
        ST_PULL_OUT
    } dbops_state_t;

    typedef struct packed {
        logic capture;
        logic init_wr;
        logic clear_wr;
        logic clear_done;
        logic draw_rd;
        logic draw_wr;
        logic pull_done;
        logic swap_done;
    } dbops_ctrl_t;

    typedef struct packed {
        logic rsp_free;
        logic sweep_last_init;
        logic sweep_last_clear;
    } dbops_stat_t;

    typedef struct packed {
        logic [7:0]         out_byte;
        logic               byte_valid;
        logic               transaction_start;
        logic               transaction_end;
        logic               frame_end;
        logic [ADDR7_W-1:0] bus_address;
        logic               swap_accepted;
        logic               busy_res;
    } dbops_rsp_word_t;

endpackage

// ===== rtl/core/dbops_cmd_if.sv =====
interface dbops_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
    logic               pixel_on;

    modport source (output valid, opcode, x_pos, y_pos, pixel_on, input ready);
    modport sink   (input valid, opcode, x_pos, y_pos, pixel_on, output ready);
endinterface

// ===== rtl/core/dbops_rsp_if.sv =====
interface dbops_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       transaction_start;
    logic       transaction_end;
    logic       frame_end;
    logic [6:0] bus_address;
    logic       swap_accepted;
    logic       busy_res;

    modport source (output valid, out_byte, byte_valid, transaction_start, transaction_end,
                    frame_end, bus_address, swap_accepted, busy_res, input ready);
    modport sink   (input valid, out_byte, byte_valid, transaction_start, transaction_end,
                    frame_end, bus_address, swap_accepted, busy_res, output ready);
endinterface

// ===== rtl/core/dbops_ram.sv =====
module dbops_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/dbops_ctrl.sv =====
module dbops_ctrl import dbops_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    input  logic [1:0]  cmd_opcode,
    output logic        cmd_ready,
    input  dbops_stat_t stat,
    output dbops_ctrl_t ctrl
);

    dbops_state_t state_reg;
    dbops_state_t state_next;
    logic         accept;

    assign accept = (state_reg == ST_IDLE) && cmd_valid && stat.rsp_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (stat.sweep_last_init)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (dbops_op_t'(cmd_opcode))
                        OP_DRAW:  state_next = ST_DRAW_RD;
                        OP_CLEAR: state_next = ST_CLEAR;
                        OP_SWAP:  state_next = ST_SWAP;
                        OP_PULL:  state_next = ST_PULL_RD;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DRAW_RD:  state_next = ST_DRAW_WR;
            ST_DRAW_WR:  state_next = ST_IDLE;
            ST_CLEAR:
            begin
                if (stat.sweep_last_clear)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SWAP:     state_next = ST_IDLE;
            ST_PULL_RD:  state_next = ST_PULL_OUT;
            ST_PULL_OUT: state_next = ST_IDLE;
            default:     state_next = ST_INIT;
        endcase
    end

    always_comb
    begin
        ctrl      = '0;
        cmd_ready = 1'b0;
        case (state_reg)
            ST_INIT:     ctrl.init_wr = 1'b1;
            ST_IDLE:
            begin
                cmd_ready    = stat.rsp_free;
                ctrl.capture = accept;
            end
            ST_DRAW_RD:  ctrl.draw_rd = 1'b1;
            ST_DRAW_WR:  ctrl.draw_wr = 1'b1;
            ST_CLEAR:
            begin
                ctrl.clear_wr   = 1'b1;
                ctrl.clear_done = stat.sweep_last_clear;
            end
            ST_SWAP:     ctrl.swap_done = 1'b1;
            ST_PULL_OUT: ctrl.pull_done = 1'b1;
            default:     ctrl = '0;
        endcase
    end

endmodule

// ===== rtl/core/dbops_datapath.sv =====
module dbops_datapath import dbops_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  dbops_ctrl_t        ctrl,
    output dbops_stat_t        stat,
    input  logic signed [15:0] x_pos,
    input  logic signed [15:0] y_pos,
    input  logic               pixel_on,
    input  logic               cfg_we,
    input  logic [ADDR7_W-1:0] cfg_wdata,
    dbops_rsp_if.source        rsp
);

    logic [15:0]        x_reg;
    logic [15:0]        y_reg;
    logic               on_reg;
    logic               front_reg;
    logic               front_next;
    logic               busy_reg;
    logic               busy_next;
    logic [PAGE_W-1:0]  page_reg;
    logic [PAGE_W-1:0]  page_next;
    logic [7:0]         bip_reg;
    logic [7:0]         bip_next;
    logic [ADDR_W-1:0]  sweep_reg;
    logic [ADDR_W-1:0]  sweep_next;
    logic [ADDR7_W-1:0] dev_addr_reg;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    dbops_rsp_word_t    rsp_reg;
    dbops_rsp_word_t    rsp_next;
    dbops_rsp_word_t    pull_word;

    logic               pix_ok;
    logic [PAGE_W-1:0]  draw_page;
    logic [ADDR_W-1:0]  draw_addr;
    logic [7:0]         pix_mask;
    logic [7:0]         pix_byte;
    logic [COL_W-1:0]   pull_col;
    logic [ADDR_W-1:0]  pull_addr;
    logic               pull_last;
    logic               page_last;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [7:0]         ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [7:0]         ram_rdata;

    function automatic logic [OFF_W-1:0] cell_offset(input logic [PAGE_W-1:0] page,
                                                     input logic [COL_W-1:0] col);
        cell_offset = OFF_W'(OFF_W'(page) * OFF_W'(PANEL_WIDTH)) + OFF_W'(col);
    endfunction

    assign pix_ok = !x_reg[15] && !y_reg[15] && (x_reg < 16'(PANEL_WIDTH))
                    && (y_reg < 16'(PANEL_HEIGHT));
    assign draw_page = y_reg[PAGE_W+2:3];
    assign draw_addr = {front_reg, cell_offset(draw_page, x_reg[COL_W-1:0])};
    assign pix_mask  = 8'd1 << y_reg[2:0];
    assign pix_byte  = on_reg ? (ram_rdata | pix_mask) : (ram_rdata & ~pix_mask);

    assign pull_col  = COL_W'(bip_reg - 8'(CMD_BYTES + 1));
    assign pull_addr = {~front_reg, cell_offset(page_reg, pull_col)};
    assign pull_last = (bip_reg == BIP_LAST);
    assign page_last = ({1'b0, page_reg} + 1'b1) >= (PAGE_W + 1)'(PAGES);

    always_comb
    begin
        ram_we    = ctrl.init_wr || ctrl.clear_wr || (ctrl.draw_wr && pix_ok);
        ram_wdata = pix_byte;
        ram_waddr = draw_addr;
        if (ctrl.init_wr)
        begin
            ram_waddr = sweep_reg;
            ram_wdata = '0;
        end
        else if (ctrl.clear_wr)
        begin
            ram_waddr = {front_reg, sweep_reg[OFF_W-1:0]};
            ram_wdata = '0;
        end
        ram_raddr = ctrl.draw_rd ? draw_addr : pull_addr;
    end

    dbops_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        pull_word = '0;
        if (busy_reg)
        begin
            pull_word.byte_valid  = 1'b1;
            pull_word.bus_address = dev_addr_reg;
            if (bip_reg < BIP_DATA_HDR)
            begin
                if (!bip_reg[0])
                begin
                    pull_word.out_byte          = CMD_CTRL;
                    pull_word.transaction_start = 1'b1;
                end
                else
                begin
                    pull_word.transaction_end = 1'b1;
                    if (bip_reg == BIP_SET_PAGE)
                    begin
                        pull_word.out_byte = SET_PAGE | 8'(page_reg);
                    end
                    else if (bip_reg == BIP_COL_HI)
                    begin
                        pull_word.out_byte = COL_HI;
                    end
                    else
                    begin
                        pull_word.out_byte = COL_LO;
                    end
                end
            end
            else if (bip_reg == BIP_DATA_HDR)
            begin
                pull_word.out_byte          = DATA_CTRL;
                pull_word.transaction_start = 1'b1;
            end
            else
            begin
                pull_word.out_byte = ram_rdata;
            end
            if (pull_last)
            begin
                pull_word.transaction_end = 1'b1;
                pull_word.frame_end       = page_last;
            end
        end
        pull_word.busy_res = busy_reg && !(pull_last && page_last);
    end

    always_comb
    begin
        front_next = front_reg;
        busy_next  = busy_reg;
        page_next  = page_reg;
        bip_next   = bip_reg;
        if (ctrl.swap_done && !busy_reg)
        begin
            front_next = ~front_reg;
            busy_next  = 1'b1;
            page_next  = '0;
            bip_next   = '0;
        end
        else if (ctrl.pull_done && busy_reg)
        begin
            if (pull_last)
            begin
                bip_next = '0;
                if (page_last)
                begin
                    busy_next = 1'b0;
                    page_next = '0;
                end
                else
                begin
                    page_next = page_reg + 1'b1;
                end
            end
            else
            begin
                bip_next = bip_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        sweep_next = sweep_reg;
        if (ctrl.clear_done)
        begin
            sweep_next = '0;
        end
        else if (ctrl.init_wr || ctrl.clear_wr)
        begin
            sweep_next = sweep_reg + 1'b1;
        end
    end

    always_comb
    begin
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        if (ctrl.pull_done)
        begin
            rsp_next       = pull_word;
            rsp_valid_next = 1'b1;
        end
        else if (ctrl.swap_done)
        begin
            rsp_next               = '0;
            rsp_next.swap_accepted = !busy_reg;
            rsp_next.busy_res      = 1'b1;
            rsp_valid_next         = 1'b1;
        end
        else if (ctrl.draw_wr || ctrl.clear_done)
        begin
            rsp_next          = '0;
            rsp_next.busy_res = busy_reg;
            rsp_valid_next    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= 1'b0;
            busy_reg      <= 1'b0;
            page_reg      <= '0;
            bip_reg       <= '0;
            sweep_reg     <= '0;
            dev_addr_reg  <= DEV_ADDR_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg     <= front_next;
            busy_reg      <= busy_next;
            page_reg      <= page_next;
            bip_reg       <= bip_next;
            sweep_reg     <= sweep_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                dev_addr_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            x_reg  <= $unsigned(x_pos);
            y_reg  <= $unsigned(y_pos);
            on_reg <= pixel_on;
        end
        rsp_reg <= rsp_next;
    end

    assign stat.rsp_free         = !rsp_valid_reg || rsp.ready;
    assign stat.sweep_last_init  = &sweep_reg;
    assign stat.sweep_last_clear = &sweep_reg[OFF_W-1:0];

    assign rsp.valid             = rsp_valid_reg;
    assign rsp.out_byte          = rsp_reg.out_byte;
    assign rsp.byte_valid        = rsp_reg.byte_valid;
    assign rsp.transaction_start = rsp_reg.transaction_start;
    assign rsp.transaction_end   = rsp_reg.transaction_end;
    assign rsp.frame_end         = rsp_reg.frame_end;
    assign rsp.bus_address       = rsp_reg.bus_address;
    assign rsp.swap_accepted     = rsp_reg.swap_accepted;
    assign rsp.busy_res          = rsp_reg.busy_res;

endmodule

// ===== rtl/core/double_buffered_oled_page_streamer.sv =====
// Double-buffered 128x128 page-mode frame buffer that streams the shown
// buffer as I2C payload bytes, one word on rsp for every word on cmd. One
// command is in progress at a time; the cost is set by the single-port-read
// frame memory: draw pixel reads, modifies and writes one byte, pull byte
// reads the memory and then gives the result, swap flips the buffers unless
// a stream is running, clear draw buffer clears one byte per cycle over
// 2048 bytes. After reset a clearing pass over all 4096 bytes zeroes both
// buffers, cmd.ready stays low meanwhile; cfg writes are taken at any time.
module double_buffered_oled_page_streamer import dbops_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    dbops_cmd_if.sink          cmd,
    dbops_rsp_if.source        rsp,
    input  logic               cfg_we,
    input  logic [ADDR7_W-1:0] cfg_wdata
);

    dbops_ctrl_t ctrl;
    dbops_stat_t stat;

    dbops_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd.valid),
        .cmd_opcode (cmd.opcode),
        .cmd_ready  (cmd.ready),
        .stat       (stat),
        .ctrl       (ctrl)
    );

    dbops_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .stat      (stat),
        .x_pos     (cmd.x_pos),
        .y_pos     (cmd.y_pos),
        .pixel_on  (cmd.pixel_on),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .rsp       (rsp)
    );

endmodule

// ===== rtl/core/dbops_checker.sv =====
`include "assert_macros.svh"

module dbops_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       cmd_valid,
    input logic       cmd_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [7:0] out_byte,
    input logic       byte_valid,
    input logic       transaction_end,
    input logic       frame_end,
    input logic       swap_accepted,
    input logic       busy_res
);

    // one command in flight: no accept right after an accept
    `DBOPS_ASSERT_NEXT(a_one_word, clk, rst_n, cmd_valid && cmd_ready, !cmd_ready)
    // a new word is only taken when the result slot drains
    `DBOPS_ASSERT_IMPL(a_no_overrun, clk, rst_n, cmd_ready && rsp_valid, rsp_ready)
    `DBOPS_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(out_byte))
    `DBOPS_ASSERT_IMPL(a_frame_end, clk, rst_n, rsp_valid && frame_end, byte_valid && transaction_end && !busy_res)
    `DBOPS_ASSERT_IMPL(a_swap_busy, clk, rst_n, rsp_valid && swap_accepted, busy_res && !byte_valid)

endmodule

bind double_buffered_oled_page_streamer dbops_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd.valid),
    .cmd_ready       (cmd.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .out_byte        (rsp.out_byte),
    .byte_valid      (rsp.byte_valid),
    .transaction_end (rsp.transaction_end),
    .frame_end       (rsp.frame_end),
    .swap_accepted   (rsp.swap_accepted),
    .busy_res        (rsp.busy_res)
);

// ===== tb/sv/double_buffered_oled_page_streamer_tb.sv =====
module double_buffered_oled_page_streamer_tb;
    import dbops_pkg::*;

    localparam int BUF_STRIDE     = 1 << OFF_W;
    localparam int HOLD_CYCLES    = 300;
    localparam int RAND_CHUNK     = 168;
    localparam int STREAM_WORDS   = 300;
    localparam int WATCHDOG_LIMIT = 20000;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [ADDR7_W-1:0] cfg_wdata;

    dbops_cmd_if cmd_bus ();
    dbops_rsp_if rsp_bus ();

    double_buffered_oled_page_streamer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_bus),
        .rsp       (rsp_bus),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #4 clk = ~clk;

    // shadow copy of the panel state
    logic [7:0]         shadow_store [STORE_DEPTH];
    logic               draw_half;
    logic               streaming;
    int                 cur_page;
    int                 cur_byte;
    logic [ADDR7_W-1:0] dev_addr_shadow;

    dbops_rsp_word_t pending_rsp_words [$];
    int              error_count = 0;
    logic            no_idle = 1'b0;
    logic            hold_req = 1'b0;

    function automatic logic signed [15:0] rand16();
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic dbops_rsp_word_t compute_rsp_word(input dbops_op_t op,
                                                         input logic signed [15:0] x,
                                                         input logic signed [15:0] y,
                                                         input logic on);
        dbops_rsp_word_t w;
        int idx;
        int b;
        int p;
        w = '0;
        b = cur_byte;
        p = cur_page;
        case (op)
            OP_DRAW:
            begin
                if (x >= 0 && y >= 0 && x < PANEL_WIDTH && y < PANEL_HEIGHT) begin
                    idx = (draw_half ? BUF_STRIDE : 0) + (int'(y) / 8) * PANEL_WIDTH + int'(x);
                    shadow_store[idx][int'(y) % 8] = on;
                end
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < BUF_STRIDE; i++)
                    shadow_store[(draw_half ? BUF_STRIDE : 0) + i] = 8'h00;
            end
            OP_SWAP:
            begin
                if (!streaming) begin
                    draw_half = ~draw_half;
                    streaming = 1'b1;
                    cur_page = 0;
                    cur_byte = 0;
                    w.swap_accepted = 1'b1;
                end
            end
            OP_PULL:
            begin
                if (streaming) begin
                    w.byte_valid = 1'b1;
                    w.bus_address = dev_addr_shadow;
                    if (b < CMD_BYTES) begin
                        if ((b & 1) == 0) begin
                            w.out_byte = CMD_CTRL;
                            w.transaction_start = 1'b1;
                        end
                        else begin
                            w.transaction_end = 1'b1;
                            if (b == BIP_SET_PAGE)
                                w.out_byte = SET_PAGE | 8'(p);
                            else if (b == BIP_COL_HI)
                                w.out_byte = COL_HI;
                            else
                                w.out_byte = COL_LO;
                        end
                    end
                    else if (b == BIP_DATA_HDR) begin
                        w.out_byte = DATA_CTRL;
                        w.transaction_start = 1'b1;
                    end
                    else begin
                        idx = (draw_half ? 0 : BUF_STRIDE) + p * PANEL_WIDTH
                              + b - int'(BIP_DATA_HDR) - 1;
                        w.out_byte = shadow_store[idx];
                    end
                    if (b >= BIP_LAST) begin
                        w.transaction_end = 1'b1;
                        cur_byte = 0;
                        if (p + 1 >= PAGES) begin
                            w.frame_end = 1'b1;
                            streaming = 1'b0;
                            cur_page = 0;
                        end
                        else begin
                            cur_page = p + 1;
                        end
                    end
                    else begin
                        cur_byte = b + 1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        w.busy_res = streaming;
        return w;
    endfunction

    task automatic send_word(input dbops_op_t op, input logic signed [15:0] x,
                             input logic signed [15:0] y, input logic on);
        while (!no_idle && $urandom_range(0, 99) < 23) begin
            cmd_bus.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_bus.valid    <= 1'b1;
        cmd_bus.opcode   <= op;
        cmd_bus.x_pos    <= x;
        cmd_bus.y_pos    <= y;
        cmd_bus.pixel_on <= on;
        @(posedge clk);
        while (cmd_bus.ready !== 1'b1)
            @(posedge clk);
        pending_rsp_words.push_back(compute_rsp_word(op, x, y, on));
    endtask

    task automatic send_random_word();
        int sel;
        dbops_op_t op;
        logic signed [15:0] x;
        logic signed [15:0] y;
        sel = $urandom_range(0, 999);
        if (sel < 8)
            op = OP_CLEAR;
        else if (sel < 70)
            op = OP_SWAP;
        else if (sel < 520)
            op = OP_PULL;
        else
            op = OP_DRAW;
        case ($urandom_range(0, 3))
            0:
            begin
                x = rand16();
                y = rand16();
            end
            1:
            begin
                // just around the panel edges
                x = 16'(int'($urandom_range(0, PANEL_WIDTH + 1)) - 1);
                y = 16'(int'($urandom_range(0, PANEL_HEIGHT + 1)) - 1);
            end
            default:
            begin
                x = 16'($urandom_range(0, PANEL_WIDTH - 1));
                y = 16'($urandom_range(0, PANEL_HEIGHT - 1));
            end
        endcase
        send_word(op, x, y, 1'($urandom));
    endtask

    task automatic wait_drained();
        cmd_bus.valid <= 1'b0;
        while (pending_rsp_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_dev_address(input logic [ADDR7_W-1:0] addr);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= addr;
        @(posedge clk);
        cfg_we <= 1'b0;
        dev_addr_shadow = addr;
    endtask

    task automatic test_directed_cases();
        set_dev_address(7'h7F);
        send_word(OP_PULL, 16'sd0, 16'sd0, 1'b0);
        send_word(OP_DRAW, 16'sd0, 16'sd0, 1'b1);
        send_word(OP_DRAW, 16'sd127, 16'sd127, 1'b1);
        send_word(OP_DRAW, 16'sd127, 16'sd0, 1'b1);
        send_word(OP_DRAW, 16'sd0, 16'sd127, 1'b1);
        send_word(OP_DRAW, 16'sd128, 16'sd0, 1'b1);
        send_word(OP_DRAW, 16'sd0, 16'sd128, 1'b1);
        send_word(OP_DRAW, -16'sd1, 16'sd5, 1'b1);
        send_word(OP_DRAW, 16'sd5, -16'sd1, 1'b1);
        send_word(OP_DRAW, -16'sd32768, -16'sd32768, 1'b1);
        send_word(OP_DRAW, 16'sd32767, 16'sd32767, 1'b1);
        send_word(OP_DRAW, 16'sd0, 16'sd0, 1'b0);
        send_word(OP_DRAW, 16'sd9, 16'sd13, 1'b1);
        send_word(OP_SWAP, 16'sd0, 16'sd0, 1'b0);
        send_word(OP_SWAP, 16'sd0, 16'sd0, 1'b0);
        repeat (8) send_word(OP_PULL, 16'sd0, 16'sd0, 1'b0);
        send_word(OP_DRAW, 16'sd9, 16'sd13, 1'b0);
        send_word(OP_CLEAR, -16'sd1, -16'sd1, 1'b1);
    endtask

    task automatic test_page_stream();
        set_dev_address(7'h00);
        no_idle = 1'b1;
        send_word(OP_CLEAR, rand16(), rand16(), 1'($urandom));
        repeat (96)
            send_word(OP_DRAW, 16'($urandom_range(0, PANEL_WIDTH - 1)),
                      16'($urandom_range(0, PANEL_HEIGHT - 1)), 1'($urandom_range(0, 7) != 0));
        send_word(OP_SWAP, rand16(), rand16(), 1'($urandom));
        repeat (STREAM_WORDS) begin
            if (cur_page >= 1)
                no_idle = 1'b0;
            if ($urandom_range(0, 9) == 0)
                send_word(OP_DRAW, rand16(), rand16(), 1'($urandom));
            else
                send_word(OP_PULL, rand16(), rand16(), 1'($urandom));
        end
        no_idle = 1'b0;
    endtask

    task automatic test_backpressure();
        set_dev_address(7'($urandom_range(1, 126)));
        hold_req = 1'b1;
        repeat (24) send_random_word();
        wait_drained();
        repeat (24) send_random_word();
    endtask

    task automatic test_random_traffic();
        logic [ADDR7_W-1:0] addrs [4];
        addrs = '{7'($urandom_range(1, 126)), 7'h7F, 7'h00, DEV_ADDR_RESET};
        for (int c = 0; c < 4; c++) begin
            set_dev_address(addrs[c]);
            repeat (RAND_CHUNK) send_random_word();
        end
    endtask

    initial begin
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_wdata        <= '0;
        cmd_bus.valid    <= 1'b0;
        cmd_bus.opcode   <= OP_DRAW;
        cmd_bus.x_pos    <= '0;
        cmd_bus.y_pos    <= '0;
        cmd_bus.pixel_on <= 1'b0;
        for (int i = 0; i < STORE_DEPTH; i++)
            shadow_store[i] = 8'h00;
        draw_half       = 1'b0;
        streaming       = 1'b0;
        cur_page        = 0;
        cur_byte        = 0;
        dev_addr_shadow = DEV_ADDR_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_page_stream();
        test_backpressure();
        test_random_traffic();

        wait_drained();
        repeat (16) @(posedge clk);
        if (error_count == 0)
            $display("double_buffered_oled_page_streamer test passed");
        else
            $display("double_buffered_oled_page_streamer test failed");
        $finish;
    end

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    // response side: random stalls, one long hold on request
    initial begin
        int hold_left;
        dbops_rsp_word_t want;
        hold_left = 0;
        rsp_bus.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
                if (pending_rsp_words.size() == 0) begin
                    $error("unexpected word: out_byte %0h busy_res %0b",
                           rsp_bus.out_byte, rsp_bus.busy_res);
                    error_count++;
                end
                else begin
                    want = pending_rsp_words.pop_front();
                    check_field("out_byte", want.out_byte, rsp_bus.out_byte);
                    check_field("byte_valid", 8'(want.byte_valid), 8'(rsp_bus.byte_valid));
                    check_field("transaction_start", 8'(want.transaction_start),
                                8'(rsp_bus.transaction_start));
                    check_field("transaction_end", 8'(want.transaction_end),
                                8'(rsp_bus.transaction_end));
                    check_field("frame_end", 8'(want.frame_end), 8'(rsp_bus.frame_end));
                    check_field("bus_address", 8'(want.bus_address), 8'(rsp_bus.bus_address));
                    check_field("swap_accepted", 8'(want.swap_accepted),
                                8'(rsp_bus.swap_accepted));
                    check_field("busy_res", 8'(want.busy_res), 8'(rsp_bus.busy_res));
                end
            end
            if (hold_req && hold_left == 0) begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end
            else if (no_idle)
                rsp_bus.ready <= 1'b1;
            else
                rsp_bus.ready <= ($urandom_range(0, 99) >= 23);
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge clk);
            if ((cmd_bus.valid === 1'b1 && cmd_bus.ready === 1'b1) ||
                (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("double_buffered_oled_page_streamer test failed");
                $finish;
            end
        end
    end

endmodule
